// ----- rtl/core/tournament_barrier_node_defines.svh -----
// Assertion macros for the tournament barrier node.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef TOURNAMENT_BARRIER_NODE_DEFINES_SVH
`define TOURNAMENT_BARRIER_NODE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define TBN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbn: assertion failed");

// Next-cycle implication.
`define TBN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbn: assertion failed");

`else

`define TBN_ASSERT_IMP(lbl, ante, cons)
`define TBN_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/tbn_pkg.sv -----
package tbn_pkg;

  localparam int RANK_W  = 16;
  localparam int COUNT_W = 17;
  localparam int ROUND_W = 5;

  // Configuration register indexes
  localparam logic CFG_MY_RANK    = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  // Phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CLIMB = 2'd1;
  localparam logic [1:0] PH_WAKE  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NOTICE  = 2'd0;
  localparam logic [1:0] KIND_WAKEUP  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Request types and message kinds
  localparam logic REQ_LOCAL  = 1'b0;
  localparam logic MSG_NOTICE = 1'b0;

  // Round roles
  localparam logic [2:0] ROLE_NONE     = 3'd0;
  localparam logic [2:0] ROLE_WINNER   = 3'd1;
  localparam logic [2:0] ROLE_LOSER    = 3'd2;
  localparam logic [2:0] ROLE_BYE      = 3'd3;
  localparam logic [2:0] ROLE_CHAMPION = 3'd4;

  // Round counter operations
  localparam logic [2:0] K_HOLD  = 3'd0;
  localparam logic [2:0] K_ONE   = 3'd1;
  localparam logic [2:0] K_CUR   = 3'd2;
  localparam logic [2:0] K_CURM1 = 3'd3;
  localparam logic [2:0] K_ZERO  = 3'd4;
  localparam logic [2:0] K_INC   = 3'd5;
  localparam logic [2:0] K_DEC   = 3'd6;

  // Result sources
  localparam logic [1:0] EM_ERR     = 2'd0;
  localparam logic [1:0] EM_NOTICE  = 2'd1;
  localparam logic [1:0] EM_WAKEUP  = 2'd2;
  localparam logic [1:0] EM_RELEASE = 2'd3;

  typedef struct packed {
    logic       in_load;
    logic [2:0] k_op;
    logic       set_pend;
    logic       clr_pend;
    logic       st_write;
    logic [1:0] st_phase;
    logic       emit;
    logic [1:0] emit_sel;
    logic       last;
  } tbn_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic ev_err;
    logic ev_store;
    logic ev_resume;
    logic ev_start;
    logic past_top;
    logic is_loser;
    logic is_wc;
    logic is_champ;
    logic bit_set;
    logic k_zero;
  } tbn_sts_t;

  // Role of rank j in round k of a group of n nodes; later tests win.
  function automatic logic [2:0] role_of(logic [RANK_W-1:0] j, logic [ROUND_W-1:0] k,
                                         logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] v1;
    logic [COUNT_W-1:0] v2;
    logic [COUNT_W-1:0] jx;
    logic [COUNT_W-1:0] m;
    logic [COUNT_W-1:0] sum;
    logic [2:0]         role;
    v1   = COUNT_W'(1) << k;
    v2   = COUNT_W'(1) << (k - ROUND_W'(1));
    jx   = {1'b0, j};
    m    = jx & (v1 - COUNT_W'(1));
    sum  = jx + v2;
    role = ROLE_NONE;
    if (jx == '0 && v1 >= n) role = ROLE_CHAMPION;
    if (m == v2) role = ROLE_LOSER;
    if (m == '0 && sum >= n) role = ROLE_BYE;
    if (m == '0 && sum < n && v1 < n) role = ROLE_WINNER;
    return role;
  endfunction

endpackage

// ----- rtl/core/tbn_if.sv -----
interface tbn_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [tbn_pkg::RANK_W-1:0] source_rank;
  logic                       msg_kind;
  modport source(output valid, req_type, source_rank, msg_kind, input ready);
  modport sink(input valid, req_type, source_rank, msg_kind, output ready);
endinterface

interface tbn_out_if;
  logic                       valid;
  logic                       ready;
  logic [tbn_pkg::RANK_W-1:0] dest_rank;
  logic [1:0]                 out_kind;
  logic                       proto_error;
  logic                       last;
  modport source(output valid, dest_rank, out_kind, proto_error, last, input ready);
  modport sink(input valid, dest_rank, out_kind, proto_error, last, output ready);
endinterface

interface tbn_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        index;
  logic [tbn_pkg::COUNT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/tournament_barrier_node.sv -----
// Tournament barrier controller for one node. Configure my_rank and node_count
// while the node is idle, then feed it local arrivals and received network
// messages on req_ch; it answers on rsp_ch with notices and wakeups to send and
// a local release, with last marking the final result of each item. Items that
// only record an early notice or park the node waiting for one give no result.
// Each accepted item is evaluated first; the round counter then climbs and
// descends one round a cycle while the output register can take a result,
// and a release ends a completed barrier. An rsp_ch stall holds the sequencer,
// since each result passes through a single output register. A finished
// result may sit in that register while the next item is accepted.
`include "tournament_barrier_node_defines.svh"

module tournament_barrier_node #(
  parameter int MAX_ROUNDS = 16  // 1..16, bounds the round count and pending mask
) (
  input logic      clk,
  input logic      rst,
  tbn_cfg_if.sink  cfg_ch,
  tbn_in_if.sink   req_ch,
  tbn_out_if.source rsp_ch
);

  tbn_pkg::tbn_cmd_t cmd;
  tbn_pkg::tbn_sts_t sts;

  // register writes always land at once
  assign cfg_ch.ready = 1'b1;

  // sequencer: accept, evaluate, climb, descend
  tbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_ch.valid),
    .in_ready (req_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // config, barrier state, role logic and the result register
  tbn_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .in_req_type     (req_ch.req_type),
    .in_source_rank  (req_ch.source_rank),
    .in_msg_kind     (req_ch.msg_kind),
    .out_valid       (rsp_ch.valid),
    .out_ready       (rsp_ch.ready),
    .out_dest_rank   (rsp_ch.dest_rank),
    .out_kind        (rsp_ch.out_kind),
    .out_proto_error (rsp_ch.proto_error),
    .out_last        (rsp_ch.last),
    .cmd             (cmd),
    .sts             (sts)
  );

  // a result is only loaded when the output register can take it
  `TBN_ASSERT_IMP(a_emit_slot, cmd.emit, sts.slot_free)
  // the final result of an item returns the sequencer to accepting
  `TBN_ASSERT_NXT(a_last_idle, cmd.emit && cmd.last, req_ch.ready)
  // an accepted item always enters evaluation, which drops ready
  `TBN_ASSERT_NXT(a_accept_busy, req_ch.valid && req_ch.ready, !req_ch.ready)
  // pending bits are never set and cleared in the same cycle
  `TBN_ASSERT_IMP(a_pend_excl, cmd.set_pend, !cmd.clr_pend)

endmodule

// ----- rtl/core/tbn_datapath.sv -----
module tbn_datapath #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tbn_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                         in_req_type,
  input  logic [tbn_pkg::RANK_W-1:0]   in_source_rank,
  input  logic                         in_msg_kind,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tbn_pkg::RANK_W-1:0]   out_dest_rank,
  output logic [1:0]                   out_kind,
  output logic                         out_proto_error,
  output logic                         out_last,
  input  tbn_pkg::tbn_cmd_t            cmd,
  output tbn_pkg::tbn_sts_t            sts
);

  localparam int RW = tbn_pkg::RANK_W;
  localparam int CW = tbn_pkg::COUNT_W;
  localparam int KW = tbn_pkg::ROUND_W;
  localparam logic [CW-1:0] CAP = CW'(1) << MAX_ROUNDS;

  // configuration
  logic [RW-1:0] my_rank;
  logic [CW-1:0] node_count;

  // barrier state
  logic [1:0]            phase;
  logic [KW-1:0]         cur_round;
  logic [MAX_ROUNDS-1:0] pending_mask;

  // working registers
  logic [KW-1:0] k;
  logic [KW-1:0] k_next;
  logic          req_type;
  logic [RW-1:0] source_rank;
  logic          msg_kind;

  logic [CW-1:0] n_eff;
  logic [KW-1:0] total;
  logic          rank_ok;
  logic [RW-1:0] diff;
  logic [KW-1:0] found;
  logic [2:0]    found_role;
  logic          found_ok;
  logic [MAX_ROUNDS-1:0] found_bit;
  logic [MAX_ROUNDS-1:0] k_bit;
  logic          notice_err;
  logic          wake_ok;
  logic [CW-1:0] v2_cur;
  logic [CW-1:0] v2_k;
  logic [2:0]    k_role;
  logic          slot_free;
  logic [RW-1:0] err_dest;
  logic [1:0]    err_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_rank    <= '0;
      node_count <= CW'(1);
    end else if (cfg_we) begin
      if (cfg_index == tbn_pkg::CFG_MY_RANK) begin
        my_rank <= cfg_data[RW-1:0];
      end else begin
        node_count <= cfg_data;
      end
    end
  end

  // group size and round count
  always_comb begin
    n_eff = (node_count > CAP) ? CAP : node_count;
    total = '0;
    for (int r = 0; r < MAX_ROUNDS; r++) begin
      if ((CW'(1) << r) < n_eff) total = KW'(r + 1);
    end
    rank_ok = {1'b0, my_rank} < n_eff;
  end

  // arrival notice: which round, if any, the sender belongs to
  always_comb begin
    diff  = source_rank - my_rank;
    found = '0;
    for (int i = 0; i < RW; i++) begin
      if (diff == (RW'(1) << i)) found = KW'(i + 1);
    end
    for (int i = 0; i < MAX_ROUNDS; i++) begin
      found_bit[i] = (found == KW'(i + 1));
      k_bit[i]     = (k == KW'(i + 1));
    end
    found_role = tbn_pkg::role_of(my_rank, found, n_eff);
    found_ok   = rank_ok && (source_rank > my_rank) && (found != '0) && (found <= total) &&
                 ((found_role == tbn_pkg::ROLE_WINNER) ||
                  (found_role == tbn_pkg::ROLE_CHAMPION));
    notice_err = !found_ok || (phase == tbn_pkg::PH_WAKE) ||
                 ((phase == tbn_pkg::PH_CLIMB) && (found < cur_round)) ||
                 ((pending_mask & found_bit) != '0);
  end

  // wakeup must come from the current round's winner
  always_comb begin
    v2_cur  = CW'(1) << (cur_round - KW'(1));
    wake_ok = (phase == tbn_pkg::PH_WAKE) && rank_ok && (cur_round != '0) &&
              (cur_round <= total) && ({1'b0, my_rank} >= v2_cur) &&
              (source_rank == RW'({1'b0, my_rank} - v2_cur));
  end

  always_comb begin
    if (req_type == tbn_pkg::REQ_LOCAL) begin
      err_dest = my_rank;
      err_kind = rank_ok ? tbn_pkg::KIND_NOTICE : tbn_pkg::KIND_RELEASE;
    end else begin
      err_dest = source_rank;
      err_kind = tbn_pkg::KIND_NOTICE;
    end
  end

  assign v2_k      = CW'(1) << (k - KW'(1));
  assign k_role    = tbn_pkg::role_of(my_rank, k, n_eff);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    sts.slot_free = slot_free;
    if (req_type == tbn_pkg::REQ_LOCAL) begin
      sts.ev_err = !rank_ok || (phase != tbn_pkg::PH_IDLE);
    end else if (msg_kind == tbn_pkg::MSG_NOTICE) begin
      sts.ev_err = notice_err;
    end else begin
      sts.ev_err = !wake_ok;
    end
    sts.ev_store  = (req_type != tbn_pkg::REQ_LOCAL) && (msg_kind == tbn_pkg::MSG_NOTICE);
    sts.ev_resume = (phase == tbn_pkg::PH_CLIMB) && (found == cur_round);
    sts.ev_start  = (req_type == tbn_pkg::REQ_LOCAL);
    sts.past_top  = k > total;
    sts.is_loser  = (k_role == tbn_pkg::ROLE_LOSER);
    sts.is_champ  = (k_role == tbn_pkg::ROLE_CHAMPION);
    sts.is_wc     = (k_role == tbn_pkg::ROLE_WINNER) || sts.is_champ;
    sts.bit_set   = (pending_mask & k_bit) != '0;
    sts.k_zero    = (k == '0);
  end

  always_comb begin
    case (cmd.k_op)
      tbn_pkg::K_ONE:   k_next = KW'(1);
      tbn_pkg::K_CUR:   k_next = cur_round;
      tbn_pkg::K_CURM1: k_next = cur_round - KW'(1);
      tbn_pkg::K_ZERO:  k_next = '0;
      tbn_pkg::K_INC:   k_next = k + KW'(1);
      tbn_pkg::K_DEC:   k_next = k - KW'(1);
      default:          k_next = k;
    endcase
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    if (cmd.in_load) begin
      req_type    <= in_req_type;
      source_rank <= in_source_rank;
      msg_kind    <= in_msg_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tbn_pkg::PH_IDLE;
      cur_round    <= '0;
      pending_mask <= '0;
    end else begin
      if (cmd.set_pend) pending_mask <= pending_mask | found_bit;
      if (cmd.clr_pend) pending_mask <= pending_mask & ~k_bit;
      if (cmd.st_write) begin
        phase     <= cmd.st_phase;
        cur_round <= (cmd.st_phase == tbn_pkg::PH_IDLE) ? '0 : k;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last        <= cmd.last;
      out_proto_error <= (cmd.emit_sel == tbn_pkg::EM_ERR);
      case (cmd.emit_sel)
        tbn_pkg::EM_ERR: begin
          out_dest_rank <= err_dest;
          out_kind      <= err_kind;
        end
        tbn_pkg::EM_NOTICE: begin
          out_dest_rank <= RW'({1'b0, my_rank} - v2_k);
          out_kind      <= tbn_pkg::KIND_NOTICE;
        end
        tbn_pkg::EM_WAKEUP: begin
          out_dest_rank <= RW'({1'b0, my_rank} + v2_k);
          out_kind      <= tbn_pkg::KIND_WAKEUP;
        end
        default: begin
          out_dest_rank <= my_rank;
          out_kind      <= tbn_pkg::KIND_RELEASE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/tbn_ctrl.sv -----
module tbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output tbn_pkg::tbn_cmd_t cmd,
  input  tbn_pkg::tbn_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_CLIMB = 2'd2;
  localparam logic [1:0] S_DESC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.k_op   = tbn_pkg::K_HOLD;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.slot_free) begin
          if (sts.ev_err) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = tbn_pkg::EM_ERR;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end else if (sts.ev_store) begin
            cmd.set_pend = 1'b1;
            if (sts.ev_resume) begin
              cmd.k_op   = tbn_pkg::K_CUR;
              state_next = S_CLIMB;
            end else begin
              state_next = S_IDLE;
            end
          end else if (sts.ev_start) begin
            cmd.k_op   = tbn_pkg::K_ONE;
            state_next = S_CLIMB;
          end else begin
            cmd.k_op   = tbn_pkg::K_CURM1;
            state_next = S_DESC;
          end
        end
      end
      S_CLIMB: begin
        if (sts.slot_free) begin
          if (sts.past_top) begin
            cmd.k_op   = tbn_pkg::K_ZERO;
            state_next = S_DESC;
          end else if (sts.is_loser) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = tbn_pkg::EM_NOTICE;
            cmd.last     = 1'b1;
            cmd.st_write = 1'b1;
            cmd.st_phase = tbn_pkg::PH_WAKE;
            state_next   = S_IDLE;
          end else if (sts.is_wc && !sts.bit_set) begin
            cmd.st_write = 1'b1;
            cmd.st_phase = tbn_pkg::PH_CLIMB;
            state_next   = S_IDLE;
          end else if (sts.is_wc) begin
            cmd.clr_pend = 1'b1;
            if (sts.is_champ) begin
              state_next = S_DESC;
            end else begin
              cmd.k_op = tbn_pkg::K_INC;
            end
          end else begin
            cmd.k_op = tbn_pkg::K_INC;
          end
        end
      end
      default: begin
        if (sts.slot_free) begin
          if (sts.k_zero) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = tbn_pkg::EM_RELEASE;
            cmd.last     = 1'b1;
            cmd.st_write = 1'b1;
            cmd.st_phase = tbn_pkg::PH_IDLE;
            state_next   = S_IDLE;
          end else begin
            cmd.emit     = sts.is_wc;
            cmd.emit_sel = tbn_pkg::EM_WAKEUP;
            cmd.k_op     = tbn_pkg::K_DEC;
          end
        end
      end
    endcase
  end

endmodule

// ----- tb/tournament_barrier_node_tb.sv -----
`timescale 1ns / 100ps

module tournament_barrier_node_tb;

  // Codes the package leaves implicit
  localparam logic REQ_NET  = 1'b1;  // message received from the network
  localparam logic MSG_WAKE = 1'b1;  // received wakeup

  localparam int MAX_RND      = 16;   // matches the DUT default
  localparam int SETTLE_CYC   = 60;   // outlasts any silent item
  localparam int HOLD_CYC     = 300;  // long receiver stall
  localparam int RANDOM_ITEMS = 130;

  typedef enum int {SEAT_NONE, SEAT_WINNER, SEAT_LOSER, SEAT_BYE, SEAT_CHAMP} seat_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] src;
    logic        msg_kind;
  } req_t;

  typedef struct packed {
    logic [15:0] dest;
    logic [1:0]  kind;
    logic        err;
    logic        last;
  } result_t;

  // Barrier predictor plus the queue of results it still owes.
  class barrier_scoreboard_t;
    bit [15:0]   rank;
    bit [16:0]   count;
    bit [1:0]    stage;
    int unsigned cur_rnd;
    bit [15:0]   pend;
    result_t     expected_q[$];
    result_t     batch[$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_wakeups;
    int          n_releases;
    int          n_notices;
    int          n_flagged;
    int          widest;

    function new();
      rank    = '0;
      count   = 17'd1;
      stage   = tbn_pkg::PH_IDLE;
      cur_rnd = 0;
      pend    = '0;
    endfunction

    function void set_reg(logic idx, logic [16:0] val);
      if (idx == tbn_pkg::CFG_MY_RANK) begin
        rank = val[15:0];
      end else begin
        count = val;
      end
    endfunction

    // Group size, clipped to what MAX_ROUNDS rounds can serve
    function int unsigned eff_n();
      return (count > 17'h10000) ? 32'h10000 : 32'(count);
    endfunction

    function int unsigned rounds_for(int unsigned n);
      int unsigned r;
      r = 0;
      while (r < MAX_RND && (32'd1 << r) < n) r++;
      return r;
    endfunction

    // Later tests override earlier ones
    function seat_t seat(int unsigned k, int unsigned n);
      int unsigned j;
      int unsigned v1;
      int unsigned v2;
      int unsigned m;
      seat_t       s;
      j  = rank;
      v1 = 32'd1 << k;
      v2 = 32'd1 << (k - 1);
      m  = j % v1;
      s  = SEAT_NONE;
      if (j == 0 && v1 >= n) s = SEAT_CHAMP;
      if (m == v2) s = SEAT_LOSER;
      if (m == 0 && j + v2 >= n) s = SEAT_BYE;
      if (m == 0 && j + v2 < n && v1 < n) s = SEAT_WINNER;
      return s;
    endfunction

    function void owe(int unsigned dest, logic [1:0] kind, logic err);
      result_t r;
      r.dest = dest[15:0];
      r.kind = kind;
      r.err  = err;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    // Wake every beaten loser from round top down, then release
    function void wake_down(int top, int unsigned n);
      seat_t s;
      for (int k = top; k >= 1; k--) begin
        s = seat(k, n);
        if (s == SEAT_WINNER || s == SEAT_CHAMP)
          owe(rank + (32'd1 << (k - 1)), tbn_pkg::KIND_WAKEUP, 1'b0);
      end
      owe(rank, tbn_pkg::KIND_RELEASE, 1'b0);
      stage   = tbn_pkg::PH_IDLE;
      cur_rnd = 0;
    endfunction

    function void climb_from(int unsigned start, int unsigned n);
      int unsigned total;
      seat_t       s;
      total = rounds_for(n);
      for (int unsigned k = start; k <= total; k++) begin
        s = seat(k, n);
        if (s == SEAT_LOSER) begin
          owe(rank - (32'd1 << (k - 1)), tbn_pkg::KIND_NOTICE, 1'b0);
          stage   = tbn_pkg::PH_WAKE;
          cur_rnd = k;
          return;
        end
        if (s == SEAT_WINNER || s == SEAT_CHAMP) begin
          if (!pend[k-1]) begin
            stage   = tbn_pkg::PH_CLIMB;
            cur_rnd = k;
            return;
          end
          pend[k-1] = 1'b0;
          if (s == SEAT_CHAMP) begin
            wake_down(k, n);
            return;
          end
        end
      end
      wake_down(0, n);
    endfunction

    function void note_item(req_t it);
      int unsigned n;
      int unsigned total;
      int unsigned found;
      int unsigned s;
      int unsigned j;
      int unsigned step;
      seat_t       st;
      n     = eff_n();
      total = rounds_for(n);
      s     = it.src;
      j     = rank;
      batch.delete();
      n_items++;
      if (it.req_type == tbn_pkg::REQ_LOCAL) begin
        if (j >= n) owe(j, tbn_pkg::KIND_RELEASE, 1'b1);
        else if (stage != tbn_pkg::PH_IDLE) owe(j, tbn_pkg::KIND_NOTICE, 1'b1);
        else climb_from(1, n);
      end else if (it.msg_kind == tbn_pkg::MSG_NOTICE) begin
        found = 0;
        if (j < n && s > j) begin
          for (int unsigned k = 1; k <= total && found == 0; k++) begin
            st = seat(k, n);
            if ((st == SEAT_WINNER || st == SEAT_CHAMP) && s - j == (32'd1 << (k - 1)))
              found = k;
          end
        end
        if (found == 0 || stage == tbn_pkg::PH_WAKE ||
            (stage == tbn_pkg::PH_CLIMB && found < cur_rnd) || pend[found-1]) begin
          owe(s, tbn_pkg::KIND_NOTICE, 1'b1);
        end else begin
          pend[found-1] = 1'b1;  // early notice, or the one the climb waits on
          if (stage == tbn_pkg::PH_CLIMB && found == cur_rnd) climb_from(cur_rnd, n);
        end
      end else begin
        step = (cur_rnd >= 1) ? (32'd1 << (cur_rnd - 1)) : 0;
        if (stage == tbn_pkg::PH_WAKE && j < n && cur_rnd >= 1 && cur_rnd <= total &&
            j >= step && s == j - step) begin
          wake_down(cur_rnd - 1, n);
        end else begin
          owe(s, tbn_pkg::KIND_NOTICE, 1'b1);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      if (batch.size() > widest) widest = batch.size();
      foreach (batch[i]) expected_q.push_back(batch[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [15:0] dest, logic [1:0] kind, logic err, logic lst);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result dest=%h kind=%0d err=%0b", dest, kind, err));
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      if (dest !== want.dest)
        report($sformatf("dest_rank %h, expected %h", dest, want.dest));
      if (kind !== want.kind)
        report($sformatf("out_kind %0d, expected %0d", kind, want.kind));
      if (err !== want.err)
        report($sformatf("proto_error %0b, expected %0b", err, want.err));
      if (lst !== want.last)
        report($sformatf("last %0b, expected %0b", lst, want.last));
      if (want.err) n_flagged++;
      else if (want.kind == tbn_pkg::KIND_WAKEUP) n_wakeups++;
      else if (want.kind == tbn_pkg::KIND_RELEASE) n_releases++;
      else n_notices++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  tbn_in_if  req_ch();
  tbn_out_if rsp_ch();
  tbn_cfg_if cfg_ch();

  tournament_barrier_node u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  barrier_scoreboard_t sb;

  bit          calm;            // no idling on either side while set
  int          hold_asked = 0;  // bumped by stimulus to request a long stall
  int          hold_done  = 0;
  int          hold_left  = 0;
  int unsigned settings_run;

  always #6 clk = ~clk;

  // Receiver: random backpressure, plus the long hold when asked for.
  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // Result monitor, sampled on the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.dest_rank, rsp_ch.out_kind, rsp_ch.proto_error, rsp_ch.last);
  end

  function automatic req_t make_req(logic rt, logic [15:0] s, logic mk);
    req_t it;
    it.req_type = rt;
    it.src      = s;
    it.msg_kind = mk;
    return it;
  endfunction

  // Mostly ranks near this node, some exact round opponents, some anywhere
  function automatic req_t random_req();
    logic [15:0] s;
    case ($urandom_range(0, 3))
      0:       s = 16'($urandom);
      1:       s = sb.rank + 16'($urandom_range(0, 16));
      2:       s = sb.rank - 16'($urandom_range(0, 16));
      default: s = sb.rank + (16'd1 << $urandom_range(0, 15));
    endcase
    return make_req(1'($urandom_range(0, 1)), s, 1'($urandom_range(0, 1)));
  endfunction

  // Offer one item; optional idle gap first. valid stays up on back-to-back items.
  task automatic send_item(req_t it);
    int unsigned gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= it.req_type;
    req_ch.source_rank <= it.src;
    req_ch.msg_kind    <= it.msg_kind;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
  endtask

  // Sender pauses until every owed result is back
  task automatic wait_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Idle point for register writes: items may finish without any result
  task automatic quiesce();
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [16:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] r, logic [16:0] n);
    settings_run++;
    if ($urandom_range(0, 1)) begin
      cfg_write(tbn_pkg::CFG_MY_RANK, {1'b0, r});
      cfg_write(tbn_pkg::CFG_NODE_COUNT, n);
    end else begin
      cfg_write(tbn_pkg::CFG_NODE_COUNT, n);
      cfg_write(tbn_pkg::CFG_MY_RANK, {1'b0, r});
    end
  endtask

  // Rank below n, often with many low zero bits so the climb goes deep
  function automatic int unsigned deep_rank(int unsigned n);
    int unsigned r;
    r = $urandom_range(0, n - 1);
    if ($urandom_range(0, 1)) r = r & ~((32'd1 << $urandom_range(1, 16)) - 1);
    return r;
  endfunction

  task automatic pick_config(int unsigned idx);
    int unsigned n;
    int unsigned r;
    case (idx)
      0: begin  // champion of the largest group: longest wakeup walk
        n = 32'h10000;
        r = 0;
      end
      1: begin  // wins fifteen rounds, loses the last
        n = 32'h10000;
        r = 32'h8000;
      end
      default: begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            n = $urandom_range(2, 40);
            r = deep_rank(n);
          end
          6: begin
            n = $urandom_range(2, 32'h10000);
            r = deep_rank(n);
          end
          7: begin  // rank outside the group
            n = $urandom_range(1, 100);
            r = n + $urandom_range(0, 50);
          end
          8: begin
            n = 1;
            r = 0;
          end
          default: begin  // count beyond 2^16 is clipped
            n = $urandom_range(32'h10001, 32'h1FFFF);
            r = $urandom_range(0, 32'hFFFF);
          end
        endcase
      end
    endcase
    set_config(16'(r), 17'(n));
  endtask

  // One barrier from this node's side: local arrival mixed into the losers'
  // notices in random order, then the winner's wakeup if this node loses.
  task automatic barrier_episode(bit broken);
    int unsigned n;
    int unsigned total;
    int unsigned lose_k;
    int unsigned j;
    bit          stop;
    logic [15:0] notices[$];
    req_t        seq[$];
    req_t        tmp;
    n      = sb.eff_n();
    total  = sb.rounds_for(n);
    lose_k = 0;
    stop   = 1'b0;
    for (int unsigned k = 1; k <= total && !stop; k++) begin
      case (sb.seat(k, n))
        SEAT_LOSER: begin
          lose_k = k;
          stop   = 1'b1;
        end
        SEAT_WINNER: notices.push_back(sb.rank + (16'd1 << (k - 1)));
        SEAT_CHAMP: begin
          notices.push_back(sb.rank + (16'd1 << (k - 1)));
          stop = 1'b1;
        end
        default: ;
      endcase
    end
    foreach (notices[i]) seq.push_back(make_req(REQ_NET, notices[i], tbn_pkg::MSG_NOTICE));
    for (int i = seq.size() - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      tmp    = seq[i];
      seq[i] = seq[j];
      seq[j] = tmp;
    end
    seq.insert($urandom_range(0, seq.size()),
               make_req(tbn_pkg::REQ_LOCAL, 16'($urandom), 1'($urandom_range(0, 1))));
    if (broken) begin
      case ($urandom_range(0, 2))
        0: begin  // repeated notice
          if (notices.size() > 0)
            seq.insert($urandom_range(0, seq.size()),
                       make_req(REQ_NET, notices[$urandom_range(0, notices.size() - 1)],
                                tbn_pkg::MSG_NOTICE));
        end
        1: seq.insert($urandom_range(0, seq.size()), random_req());
        default: begin  // stray wakeup ahead of the real one
          if (lose_k != 0) seq.push_back(make_req(REQ_NET, 16'($urandom), MSG_WAKE));
        end
      endcase
    end
    if (lose_k != 0)
      seq.push_back(make_req(REQ_NET, sb.rank - (16'd1 << (lose_k - 1)), MSG_WAKE));
    foreach (seq[i]) send_item(seq[i]);
  endtask

  task automatic noise_burst();
    int unsigned cnt;
    cnt = $urandom_range(3, 8);
    repeat (cnt) send_item(random_req());
  endtask

  // Feed the message the node waits for, so the next setting starts idle
  task automatic settle();
    int unsigned n;
    int unsigned tries;
    logic [15:0] step;
    n     = sb.eff_n();
    tries = 0;
    while (sb.stage != tbn_pkg::PH_IDLE && sb.rank < n && sb.cur_rnd >= 1 && tries < 40) begin
      step = 16'd1 << (sb.cur_rnd - 1);
      if (sb.stage == tbn_pkg::PH_CLIMB) begin
        send_item(make_req(REQ_NET, sb.rank + step, tbn_pkg::MSG_NOTICE));
      end else begin
        send_item(make_req(REQ_NET, sb.rank - step, MSG_WAKE));
      end
      tries++;
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned idx;
    int unsigned rep;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = tbn_pkg::REQ_LOCAL;
    req_ch.source_rank = '0;
    req_ch.msg_kind    = tbn_pkg::MSG_NOTICE;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = tbn_pkg::CFG_MY_RANK;
    cfg_ch.data        = '0;
    rsp_ch.ready       = 1'b0;
    rst                = 1'b1;
    calm               = 1'b0;
    settings_run       = 0;
    sb                 = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers: a lone node releases at once; any notice is foreign.
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'h0000, tbn_pkg::MSG_NOTICE));
    send_item(make_req(REQ_NET, 16'hFFFF, tbn_pkg::MSG_NOTICE));

    // Rank 0 of 6: wins rounds 1-2, champion in round 3.
    quiesce();
    set_config(16'd0, 17'd6);
    send_item(make_req(REQ_NET, 16'd2, tbn_pkg::MSG_NOTICE));    // early, kept
    send_item(make_req(REQ_NET, 16'd2, tbn_pkg::MSG_NOTICE));    // duplicate
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'hFFFF, MSG_WAKE)); // parks in round 1
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'd0, tbn_pkg::MSG_NOTICE)); // arrival while busy
    send_item(make_req(REQ_NET, 16'd1, tbn_pkg::MSG_NOTICE));    // climbs to round 3
    send_item(make_req(REQ_NET, 16'd2, tbn_pkg::MSG_NOTICE));    // round already passed
    send_item(make_req(REQ_NET, 16'd4, tbn_pkg::MSG_NOTICE));    // champion walks down

    // Rank 4 of 6: wins round 1, bye in 2, loses round 3 to rank 0.
    quiesce();
    set_config(16'd4, 17'd6);
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'd0, tbn_pkg::MSG_NOTICE));
    send_item(make_req(REQ_NET, 16'd5, tbn_pkg::MSG_NOTICE));    // sends own notice
    send_item(make_req(REQ_NET, 16'd5, tbn_pkg::MSG_NOTICE));    // notice while waiting
    send_item(make_req(REQ_NET, 16'd3, MSG_WAKE));               // wrong winner
    send_item(make_req(REQ_NET, 16'd0, MSG_WAKE));               // woken

    // Rank outside the group, then an empty group
    quiesce();
    set_config(16'd7, 17'd5);
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'd7, tbn_pkg::MSG_NOTICE));
    quiesce();
    set_config(16'd0, 17'd0);
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'd0, tbn_pkg::MSG_NOTICE));

    // Top rank with a clipped count: loses round 1 at once
    quiesce();
    set_config(16'hFFFF, 17'h1FFFF);
    send_item(make_req(tbn_pkg::REQ_LOCAL, 16'hFFFF, MSG_WAKE));
    send_item(make_req(REQ_NET, 16'hFFFE, MSG_WAKE));
    settle();

    // Random settings, mostly well-formed barriers with random ordering
    base = sb.n_items;
    idx  = 0;
    while (sb.n_items - base < RANDOM_ITEMS) begin
      quiesce();
      pick_config(idx);
      calm = (idx >= 3 && idx <= 5);
      if (idx == 2) begin
        // Stalled receiver while every item answers: input must back up
        hold_asked++;
        repeat (20) send_item(make_req(REQ_NET, 16'($urandom), MSG_WAKE));
      end else begin
        rep = (idx < 2) ? 1 : $urandom_range(1, 3);
        repeat (rep) begin
          if ($urandom_range(0, 99) < 80) barrier_episode($urandom_range(0, 99) < 15);
          else noise_burst();
          if ($urandom_range(0, 3) == 0) wait_results();
        end
      end
      settle();
      idx++;
    end
    calm = 1'b0;

    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
    $display("run covered %0d items under %0d register settings, %0d results checked",
             sb.n_items, settings_run, sb.n_results);
    $display("  %0d wakeups, %0d releases, %0d notices, %0d flagged; longest answer %0d",
             sb.n_wakeups, sb.n_releases, sb.n_notices, sb.n_flagged, sb.widest);
    if (sb.errors == 0) begin
      $display("tournament_barrier_node_tb passed");
    end else begin
      $display("tournament_barrier_node_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(6_000_000);
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("tournament_barrier_node_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tbn_pkg.sv
rtl/core/tbn_if.sv
rtl/core/tbn_datapath.sv
rtl/core/tbn_ctrl.sv
rtl/core/tournament_barrier_node.sv
tb/tournament_barrier_node_tb.sv
